[src/gcma_pkg.sv]
`default_nettype none
package gcma_pkg;

  localparam int DEF_MAX_SIDE   = 256;
  localparam int DEF_COUNT_BITS = 16;
  localparam int COORD_W        = 32;
  localparam int STEP_W         = 31;
  localparam int SIDE_CFG_W     = 9;
  localparam int CFG_IDX_W      = 8;
  localparam int CFG_DATA_W     = 32;

  localparam logic [STEP_W-1:0]     STEP_RESET = STEP_W'(65536);
  localparam logic [SIDE_CFG_W-1:0] SIDE_RESET = SIDE_CFG_W'(255);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 8'd0,
    CFG_ORIGIN_Y = 8'd1,
    CFG_STEP     = 8'd2,
    CFG_SIDE     = 8'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_GET_PT = 2'd1,
    REQ_GET_CR = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    RES_OK      = 2'd0,
    RES_OUTSIDE = 2'd1,
    RES_EMPTY   = 2'd2,
    RES_FULL    = 2'd3
  } res_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_CHECK,
    OP_EVAL,
    OP_DIVX,
    OP_DIVY,
    OP_INDEX,
    OP_READ,
    OP_UPDATE,
    OP_MINIT,
    OP_MDIV,
    OP_ROUND
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       out_load;
    logic [1:0] res_code;
  } dp_cmd_t;

  typedef struct packed {
    logic in_grid;
    logic is_add;
    logic is_point;
    logic cnt_last;
    logic clr_last;
    logic full;
    logic empty;
  } dp_sts_t;

endpackage
`default_nettype wire

[src/grid_cell_mean_accumulator_unit.sv]
`default_nettype none
// Steps: bounds check, two coordinate divider passes for point requests, index, read;
// adds update a non-full cell, gets of a non-empty cell run the mean divider and round.
// Throughput: one request at a time, set by the two coordinate divider passes
// and the bit-serial mean divider; the next request enters while a result waits.
// Reset: synchronous active-low; afterwards a clearing pass over all MAX_SIDE*MAX_SIDE
// cells zeroes the cell store, requests are held off while it runs.
module grid_cell_mean_accumulator_unit #(
  parameter int MAX_SIDE   = gcma_pkg::DEF_MAX_SIDE,
  parameter int COUNT_BITS = gcma_pkg::DEF_COUNT_BITS
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_we,
  input  wire  [gcma_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [gcma_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  [1:0]                           in_req_type,
  input  wire  signed [gcma_pkg::COORD_W-1:0]  in_point_x,
  input  wire  signed [gcma_pkg::COORD_W-1:0]  in_point_y,
  input  wire  [7:0]                           in_cell_col,
  input  wire  [7:0]                           in_cell_row,
  input  wire  signed [gcma_pkg::COORD_W-1:0]  in_sample_value,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [1:0]                           out_status,
  output logic signed [gcma_pkg::COORD_W-1:0]  out_cell_mean
);
  import gcma_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: clear sweep, request steps, result handoff
  gcma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: config, dividers, cell store, result register
  gcma_datapath #(
    .MAX_SIDE   (MAX_SIDE),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_req_type     (in_req_type),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_cell_col     (in_cell_col),
    .in_cell_row     (in_cell_row),
    .in_sample_value (in_sample_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_status      (out_status),
    .out_cell_mean   (out_cell_mean)
  );

endmodule
`default_nettype wire

[src/gcma_datapath.sv]
`default_nettype none
module gcma_datapath #(
  parameter int MAX_SIDE   = gcma_pkg::DEF_MAX_SIDE,
  parameter int COUNT_BITS = gcma_pkg::DEF_COUNT_BITS
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_we,
  input  wire  [gcma_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [gcma_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire  [1:0]                           in_req_type,
  input  wire  signed [gcma_pkg::COORD_W-1:0]  in_point_x,
  input  wire  signed [gcma_pkg::COORD_W-1:0]  in_point_y,
  input  wire  [7:0]                           in_cell_col,
  input  wire  [7:0]                           in_cell_row,
  input  wire  signed [gcma_pkg::COORD_W-1:0]  in_sample_value,
  input  gcma_pkg::dp_cmd_t                    cmd,
  output gcma_pkg::dp_sts_t                    sts,
  output logic [1:0]                           out_status,
  output logic signed [gcma_pkg::COORD_W-1:0]  out_cell_mean
);
  import gcma_pkg::*;

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int QW     = $clog2(MAX_SIDE);
  localparam int CELLS  = MAX_SIDE * MAX_SIDE;
  localparam int IDX_W  = $clog2(CELLS);
  localparam int SUM_W  = COORD_W + COUNT_BITS;
  localparam int WORD_W = SUM_W + COUNT_BITS;
  localparam int EXT_W  = STEP_W + SIDE_W;
  localparam int XDV_W  = STEP_W + QW;
  localparam int XR_W   = XDV_W + 1;
  localparam int CNT_W  = $clog2(SUM_W);
  localparam int CMP_W  = (SIDE_W > SIDE_CFG_W) ? SIDE_W : SIDE_CFG_W;

  // configuration
  logic [COORD_W-1:0]    org_x_r, org_y_r;
  logic [STEP_W-1:0]     step_r;
  logic [SIDE_CFG_W-1:0] side_cfg_r;

  // captured request
  logic [1:0]         req_r;
  logic [COORD_W-1:0] px_r, py_r, sample_r;
  logic [7:0]         ccol_r, crow_r;

  logic signed [COORD_W:0] dx_r, dy_r;
  logic [EXT_W-1:0]        ext_r;
  logic [XR_W-1:0]         xrem_r;
  logic [XDV_W-1:0]        xdiv_r;
  logic [QW-1:0]           q_r, col_r, row_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [IDX_W-1:0]        idx_r, clr_cnt_r;
  logic [WORD_W-1:0]       rd_r;
  logic [WORD_W-1:0]       mem [CELLS];

  logic [SUM_W-1:0]      mdvd_r, mq_r;
  logic [COUNT_BITS-1:0] mrem_r, mcnt_r;
  logic                  neg_r;
  logic [COORD_W-1:0]    mean_r;
  logic [1:0]            out_status_r;
  logic [COORD_W-1:0]    out_mean_r;

  logic [CMP_W-1:0]  side_ext;
  logic [SIDE_W-1:0] side_cur;
  logic              in_x, in_y, in_cr;
  logic              xge;
  logic [XR_W-1:0]   xrem_nxt;
  logic [QW-1:0]     q_nxt;
  logic [SUM_W-1:0]      rd_sum, new_sum, q_rnd;
  logic [COUNT_BITS-1:0] rd_cnt, new_cnt;
  logic [COUNT_BITS:0]   mt;
  logic                  mge, rup;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_wa;
  logic [WORD_W-1:0]     mem_wd;

  always_comb begin
    side_ext = CMP_W'(side_cfg_r);
    if (side_ext > CMP_W'(MAX_SIDE)) begin
      side_cur = SIDE_W'(MAX_SIDE);
    end else begin
      side_cur = SIDE_W'(side_ext);
    end
  end

  // strict interior test on each axis
  assign in_x  = !dx_r[COORD_W] && (dx_r != '0) && (EXT_W'(dx_r[COORD_W-1:0]) < ext_r);
  assign in_y  = !dy_r[COORD_W] && (dy_r != '0) && (EXT_W'(dy_r[COORD_W-1:0]) < ext_r);
  assign in_cr = (CMP_W'(ccol_r) < CMP_W'(side_cur)) && (CMP_W'(crow_r) < CMP_W'(side_cur));

  always_comb begin
    case (req_r)
      REQ_ADD, REQ_GET_PT: sts.in_grid = in_x && in_y;
      REQ_GET_CR:          sts.in_grid = in_cr;
      default:             sts.in_grid = 1'b0;
    endcase
  end

  assign sts.is_add   = (req_r == REQ_ADD);
  assign sts.is_point = (req_r == REQ_ADD) || (req_r == REQ_GET_PT);
  assign sts.cnt_last = (cnt_r == '0);
  assign sts.clr_last = (clr_cnt_r == IDX_W'(CELLS - 1));

  assign rd_sum     = rd_r[WORD_W-1:COUNT_BITS];
  assign rd_cnt     = rd_r[COUNT_BITS-1:0];
  assign sts.full   = &rd_cnt;
  assign sts.empty  = (rd_cnt == '0);

  // one restoring step of the coordinate divider
  assign xge      = xrem_r >= XR_W'(xdiv_r);
  assign xrem_nxt = xge ? (xrem_r - XR_W'(xdiv_r)) : xrem_r;
  assign q_nxt    = QW'({q_r, xge});

  // one step of the bit-serial mean divider
  assign mt       = {mrem_r, mdvd_r[SUM_W-1]};
  assign mge      = mt >= {1'b0, mcnt_r};
  assign rup      = {mrem_r, 1'b0} >= {1'b0, mcnt_r};
  assign q_rnd    = mq_r + SUM_W'(rup);

  assign new_sum  = rd_sum + {{COUNT_BITS{sample_r[COORD_W-1]}}, sample_r};
  assign new_cnt  = rd_cnt + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r    <= '0;
      org_y_r    <= '0;
      step_r     <= STEP_RESET;
      side_cfg_r <= SIDE_RESET;
      clr_cnt_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ORIGIN_X: org_x_r    <= cfg_data;
          CFG_ORIGIN_Y: org_y_r    <= cfg_data;
          CFG_STEP:     step_r     <= cfg_data[STEP_W-1:0];
          CFG_SIDE:     side_cfg_r <= cfg_data[SIDE_CFG_W-1:0];
          default:      ;
        endcase
      end
      if (cmd.op == OP_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        req_r    <= in_req_type;
        px_r     <= in_point_x;
        py_r     <= in_point_y;
        ccol_r   <= in_cell_col;
        crow_r   <= in_cell_row;
        sample_r <= in_sample_value;
        mean_r   <= '0;
      end
      OP_CHECK: begin
        dx_r  <= $signed({px_r[COORD_W-1], px_r}) - $signed({org_x_r[COORD_W-1], org_x_r});
        dy_r  <= $signed({py_r[COORD_W-1], py_r}) - $signed({org_y_r[COORD_W-1], org_y_r});
        ext_r <= EXT_W'(side_cur) * EXT_W'(step_r);
      end
      OP_EVAL: begin
        col_r  <= QW'(ccol_r);
        row_r  <= QW'(crow_r);
        xrem_r <= XR_W'(dx_r[COORD_W-1:0]);
        xdiv_r <= XDV_W'(step_r) << (QW - 1);
        q_r    <= '0;
        cnt_r  <= CNT_W'(QW - 1);
      end
      OP_DIVX: begin
        if (cnt_r == '0) begin
          col_r  <= q_nxt;
          xrem_r <= XR_W'(dy_r[COORD_W-1:0]);
          xdiv_r <= XDV_W'(step_r) << (QW - 1);
          q_r    <= '0;
          cnt_r  <= CNT_W'(QW - 1);
        end else begin
          xrem_r <= xrem_nxt;
          xdiv_r <= xdiv_r >> 1;
          q_r    <= q_nxt;
          cnt_r  <= cnt_r - 1'b1;
        end
      end
      OP_DIVY: begin
        xrem_r <= xrem_nxt;
        xdiv_r <= xdiv_r >> 1;
        q_r    <= q_nxt;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          row_r <= q_nxt;
        end
      end
      OP_INDEX: begin
        idx_r <= IDX_W'(col_r) + IDX_W'(side_cur) * IDX_W'(row_r);
      end
      OP_MINIT: begin
        neg_r  <= rd_sum[SUM_W-1];
        mdvd_r <= rd_sum[SUM_W-1] ? (~rd_sum + 1'b1) : rd_sum;
        mcnt_r <= rd_cnt;
        mrem_r <= '0;
        mq_r   <= '0;
        cnt_r  <= CNT_W'(SUM_W - 1);
      end
      OP_MDIV: begin
        mrem_r <= mge ? COUNT_BITS'(mt - {1'b0, mcnt_r}) : COUNT_BITS'(mt);
        mq_r   <= {mq_r[SUM_W-2:0], mge};
        mdvd_r <= mdvd_r << 1;
        cnt_r  <= cnt_r - 1'b1;
      end
      OP_ROUND: begin
        mean_r <= neg_r ? COORD_W'(~q_rnd + 1'b1) : COORD_W'(q_rnd);
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      out_status_r <= cmd.res_code;
      out_mean_r   <= mean_r;
    end
  end

  // single write port: clearing sweep or read-modify-write
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_r;
    mem_wd = {new_sum, new_cnt};
    if (cmd.op == OP_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = '0;
    end else if (cmd.op == OP_UPDATE) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_READ) begin
      rd_r <= mem[idx_r];
    end
  end

  assign out_status    = out_status_r;
  assign out_cell_mean = out_mean_r;

endmodule
`default_nettype wire

[src/gcma_ctrl.sv]
`default_nettype none
module gcma_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire                out_ready,
  input  gcma_pkg::dp_sts_t  sts,
  output gcma_pkg::dp_cmd_t  cmd
);
  import gcma_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_EVAL,
    S_DIVX,
    S_DIVY,
    S_INDEX,
    S_READ,
    S_DECIDE,
    S_MDIV,
    S_ROUND,
    S_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] code_r, code_nxt;

  always_comb begin
    state_nxt    = state_r;
    code_nxt     = code_r;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    cmd.res_code = code_r;
    case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.op    = OP_CHECK;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.op = OP_EVAL;
        if (!sts.in_grid) begin
          code_nxt  = RES_OUTSIDE;
          state_nxt = S_FIN;
        end else if (sts.is_point) begin
          state_nxt = S_DIVX;
        end else begin
          state_nxt = S_INDEX;
        end
      end
      S_DIVX: begin
        cmd.op = OP_DIVX;
        if (sts.cnt_last) state_nxt = S_DIVY;
      end
      S_DIVY: begin
        cmd.op = OP_DIVY;
        if (sts.cnt_last) state_nxt = S_INDEX;
      end
      S_INDEX: begin
        cmd.op    = OP_INDEX;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.op    = OP_READ;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.is_add) begin
          state_nxt = S_FIN;
          if (sts.full) begin
            code_nxt = RES_FULL;
          end else begin
            cmd.op   = OP_UPDATE;
            code_nxt = RES_OK;
          end
        end else if (sts.empty) begin
          code_nxt  = RES_EMPTY;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_MINIT;
          state_nxt = S_MDIV;
        end
      end
      S_MDIV: begin
        cmd.op = OP_MDIV;
        if (sts.cnt_last) state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.op    = OP_ROUND;
        code_nxt  = RES_OK;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
      code_r      <= RES_OUTSIDE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      code_r      <= code_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_FIN))
    else $error("result shown without finishing a request");

  a_update_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_UPDATE |-> sts.is_add && !sts.full)
    else $error("store update on a full cell or non-add request");

endmodule
`default_nettype wire

[bench/tb_grid_cell_mean_accumulator_unit.sv]
`timescale 1ns / 1ps
module tb_grid_cell_mean_accumulator_unit;
  import gcma_pkg::*;

  localparam int SIDE_CAP  = DEF_MAX_SIDE;
  localparam int COUNT_TOP = (1 << DEF_COUNT_BITS) - 1;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] mean;
  } cell_answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  wire         in_ready;
  logic [1:0]  in_req_type = REQ_ADD;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic [7:0]  in_cell_col = '0;
  logic [7:0]  in_cell_row = '0;
  logic signed [31:0] in_sample_value = '0;
  wire         out_valid;
  logic        out_ready = 1'b0;
  wire  [1:0]  out_status;
  wire  signed [31:0] out_cell_mean;

  // Shadow copy of the grid configuration and the cell store.
  longint      grid_org_x, grid_org_y;
  logic [30:0] grid_step;
  logic [8:0]  grid_side;
  longint      cell_sums[int];
  int          cell_counts[int];

  cell_answer_t answers_due[$];
  int          errors = 0;
  bit          fast_mode = 1'b0;

  grid_cell_mean_accumulator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_point_x(in_point_x), .in_point_y(in_point_y),
    .in_cell_col(in_cell_col), .in_cell_row(in_cell_row),
    .in_sample_value(in_sample_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_cell_mean(out_cell_mean)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Map one coordinate onto the grid; return -1 when not strictly inside.
  function automatic longint axis_cell(input logic signed [31:0] p, input longint org,
                                       input longint side);
    longint d, ext;
    d   = longint'(p) - org;
    ext = side * longint'(grid_step);
    if (grid_step == 0 || d <= 0 || d >= ext) return -1;
    return d / longint'(grid_step);
  endfunction

  // Rounded mean, ties away from zero.
  function automatic logic [31:0] mean_of(input longint s, input longint c);
    longint mag, q, r;
    mag = (s < 0) ? -s : s;
    q   = mag / c;
    r   = mag % c;
    if (r >= c - r) q++;
    if (s < 0) q = -q;
    return q[31:0];
  endfunction

  // Work out the answer to one accepted request and update the shadow store.
  task automatic predict_cell_answer(input logic [1:0] kind, input logic signed [31:0] px,
                                     input logic signed [31:0] py, input logic [7:0] col,
                                     input logic [7:0] row, input logic signed [31:0] val);
    cell_answer_t a;
    longint side, cx, cy, idx, cnt, sum;
    a.status = RES_OUTSIDE;
    a.mean   = '0;
    side = (grid_side > SIDE_CAP) ? SIDE_CAP : grid_side;
    cx = -1;
    cy = -1;
    if (kind == REQ_ADD || kind == REQ_GET_PT) begin
      cx = axis_cell(px, grid_org_x, side);
      cy = axis_cell(py, grid_org_y, side);
    end else if (kind == REQ_GET_CR && col < side && row < side) begin
      cx = col;
      cy = row;
    end
    if (cx >= 0 && cy >= 0) begin
      idx = cx + side * cy;
      cnt = cell_counts.exists(idx) ? cell_counts[idx] : 0;
      sum = cell_sums.exists(idx) ? cell_sums[idx] : 0;
      if (kind == REQ_ADD) begin
        if (cnt >= COUNT_TOP) begin
          a.status = RES_FULL;
        end else begin
          cell_sums[idx]   = sum + longint'(val);
          cell_counts[idx] = cnt + 1;
          a.status = RES_OK;
        end
      end else if (cnt == 0) begin
        a.status = RES_EMPTY;
      end else begin
        a.status = RES_OK;
        a.mean   = mean_of(sum, cnt);
      end
    end
    answers_due.push_back(a);
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (fast_mode || roll < 40) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Send one request; keep valid high across back-to-back requests.
  task automatic send_request(input logic [1:0] kind, input logic signed [31:0] px,
                              input logic signed [31:0] py, input logic [7:0] col,
                              input logic [7:0] row, input logic signed [31:0] val);
    int gap;
    in_valid        <= 1'b1;
    in_req_type     <= kind;
    in_point_x      <= px;
    in_point_y      <= py;
    in_cell_col     <= col;
    in_cell_row     <= row;
    in_sample_value <= val;
    do @(posedge clk); while (!in_ready);
    predict_cell_answer(kind, px, py, col, row, val);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain outstanding requests, then write one register while idle.
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ORIGIN_X: grid_org_x = longint'($signed(value));
      CFG_ORIGIN_Y: grid_org_y = longint'($signed(value));
      CFG_STEP:     grid_step  = value[30:0];
      CFG_SIDE:     grid_side  = value[8:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(input logic [31:0] ox, input logic [31:0] oy,
                          input logic [31:0] step, input logic [31:0] side);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_STEP, step);
    write_reg(CFG_SIDE, side);
  endtask

  // Reset configuration: corners, boundaries, every request kind, rounding.
  task automatic test_directed_defaults();
    send_request(REQ_GET_PT, 32'sh8000, 32'sh8000, 0, 0, 0);          // empty cell
    send_request(REQ_ADD, 32'sh8000, 32'sh8000, 0, 0, 32'sh7fffffff);
    send_request(REQ_ADD, 32'sh8000, 32'sh8000, 0, 0, 32'sh7fffffff);
    send_request(REQ_GET_PT, 32'sh8000, 32'sh8000, 0, 0, 0);
    send_request(REQ_ADD, 32'sh18000, 32'sh8000, 0, 0, 32'sh80000000);
    send_request(REQ_ADD, 32'sh18000, 32'sh8000, 0, 0, 32'sh80000000);
    send_request(REQ_ADD, 32'sh18000, 32'sh8000, 0, 0, 32'sh00000001);
    send_request(REQ_GET_CR, 0, 0, 1, 0, 0);
    send_request(REQ_ADD, 32'sh28000, 32'sh8000, 0, 0, -32'sd3);       // negative tie
    send_request(REQ_ADD, 32'sh28000, 32'sh8000, 0, 0, 32'sd0);
    send_request(REQ_GET_CR, 0, 0, 2, 0, 0);
    send_request(REQ_ADD, 0, 32'sh8000, 0, 0, 5);                      // on the edge
    send_request(REQ_ADD, 32'sh00ff0000, 32'sh8000, 0, 0, 5);          // far edge
    send_request(REQ_ADD, 32'sh00feffff, 32'sh00feffff, 0, 0, 9);      // last cell
    send_request(REQ_GET_CR, 0, 0, 254, 254, 0);
    send_request(REQ_GET_CR, 0, 0, 255, 0, 0);                         // column too big
    send_request(REQ_GET_CR, 0, 0, 0, 255, 0);
    send_request(REQ_GET_PT, 32'sh80000000, 32'sh7fffffff, 0, 0, 0);
    send_request(REQ_NONE, 32'sh8000, 32'sh8000, 0, 0, 7);
    send_request(REQ_GET_CR, 0, 0, 0, 0, 0);
  endtask

  // Register extremes: zero side, zero step, oversized side, far origins.
  task automatic test_config_extremes();
    set_grid(32'h80000000, 32'h80000000, 32'hffffffff, 32'd256);
    send_request(REQ_ADD, 32'sh7fffffff, 32'sh80000001, 0, 0, 32'sh12345678);
    send_request(REQ_GET_CR, 0, 0, 0, 0, 0);
    send_request(REQ_GET_CR, 0, 0, 255, 255, 0);
    write_reg(CFG_SIDE, 32'h1ff);
    send_request(REQ_GET_CR, 0, 0, 255, 255, 0);
    write_reg(CFG_SIDE, 32'd0);
    send_request(REQ_GET_CR, 0, 0, 0, 0, 0);
    send_request(REQ_ADD, 32'sh7fffffff, 32'sh80000001, 0, 0, 1);
    set_grid(32'h7fffffff, 32'hfffffff0, 32'd0, 32'd4);
    send_request(REQ_ADD, 32'sh7fffffff, 32'shfffffff1, 0, 0, 1);
    send_request(REQ_GET_CR, 0, 0, 0, 0, 0);
    set_grid(32'd0, 32'd0, 32'd1, 32'd2);
    send_request(REQ_ADD, 32'sd1, 32'sd1, 0, 0, 11);
    send_request(REQ_GET_PT, 32'sd1, 32'sd1, 0, 0, 0);
    send_request(REQ_GET_PT, 32'sd2, 32'sd1, 0, 0, 0);
  endtask

  // Pile samples onto one cell back to back, then read its mean.
  task automatic test_hot_cell();
    set_grid(32'd0, 32'd0, 32'h10000, 32'd255);
    fast_mode = 1'b1;
    repeat (40)
      send_request(REQ_ADD, 32'sh00508000, 32'sh00508000, 0, 0,
                   $signed({{18{1'b0}}, 14'($urandom)}) - 32'sd8192);
    fast_mode = 1'b0;
    send_request(REQ_GET_CR, 0, 0, 80, 80, 0);
  endtask

  // Random phases: mostly in-grid requests, some noise anywhere.
  task automatic test_random_traffic();
    logic [31:0] ox, oy, step, side;
    longint ext;
    int roll;
    logic [1:0] kind;
    logic signed [31:0] px, py;
    for (int ph = 0; ph < 6; ph++) begin
      ox   = $signed($urandom_range(32'h01ffffff)) - 32'sh01000000;
      oy   = $signed($urandom_range(32'h01ffffff)) - 32'sh01000000;
      step = (ph == 0) ? 32'd1 : $urandom_range(32'h40000, 1) | (ph == 5 ? 32'h80000000 : 0);
      side = (ph == 1) ? 32'd256 : (ph == 2) ? 32'd1 : $urandom_range(24, 2);
      if (ph == 3) begin
        ox = $urandom;
        oy = $urandom;
      end
      set_grid(ox, oy, step, side);
      ext = longint'(grid_side) * longint'(grid_step);
      for (int n = 0; n < 80; n++) begin
        roll = $urandom_range(99);
        kind = (roll < 50) ? REQ_ADD : (roll < 75) ? REQ_GET_PT :
               (roll < 95) ? REQ_GET_CR : REQ_NONE;
        if ($urandom_range(9) < 8 && ext > 1) begin
          px = 32'(grid_org_x + longint'($urandom_range(32'(ext - 1), 1)));
          py = 32'(grid_org_y + longint'($urandom_range(32'(ext - 1), 1)));
        end else begin
          px = $urandom;
          py = $urandom;
        end
        if ($urandom_range(9) < 8 && grid_side != 0)
          send_request(kind, px, py, 8'($urandom_range(grid_side - 1)),
                       8'($urandom_range(grid_side - 1)), $urandom);
        else
          send_request(kind, px, py, 8'($urandom), 8'($urandom), $urandom);
      end
    end
  endtask

  // Result checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result status %0d mean %h", $time, out_status,
                 out_cell_mean);
        errors++;
      end else begin
        if (out_status !== answers_due[0].status) begin
          $display("%0t: status expected %0d actual %0d", $time, answers_due[0].status,
                   out_status);
          errors++;
        end
        if (out_cell_mean !== answers_due[0].mean) begin
          $display("%0t: mean expected %h actual %h", $time, answers_due[0].mean,
                   out_cell_mean);
          errors++;
        end
        void'(answers_due.pop_front());
      end
    end
  end

  // Result-side stalls; none during the fast burst.
  initial begin
    int n;
    @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    grid_org_x = 0;
    grid_org_y = 0;
    grid_step  = STEP_RESET;
    grid_side  = SIDE_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_defaults();
    test_config_extremes();
    test_hot_cell();
    test_random_traffic();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (errors == 0) begin
      $display("grid_cell_mean_accumulator_unit: match");
    end else begin
      $display("grid_cell_mean_accumulator_unit: mismatch");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #400_000_000;
    $display("grid_cell_mean_accumulator_unit: mismatch");
    $finish;
  end

endmodule
